// ===== src/irtp_pkg.sv =====
// shared types, constants and register codes for the tachometer position tracker
`default_nettype none

package irtp_pkg;

    // adaptive debounce divisor and its reciprocal for the constant divide
    localparam int unsigned DEBOUNCE_DIVISOR = 10;
    localparam int unsigned DIV_SHIFT        = 32 + $clog2(DEBOUNCE_DIVISOR);
    localparam logic [64:0] DIV_MAGIC_FULL   =
        ((65'd1 << DIV_SHIFT) / DEBOUNCE_DIVISOR) + 65'd1;
    localparam logic [32:0] DIV_MAGIC        = DIV_MAGIC_FULL[32:0];

    // field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DEB_W   = 24;
    localparam int unsigned MARKS_W = 8;
    localparam int unsigned CFG_AW  = 4;

    // register reset values
    localparam logic [DEB_W-1:0]   DEB_MIN_RST   = 24'd10000;
    localparam logic [DEB_W-1:0]   DEB_MAX_RST   = 24'd120000;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST   = 32'd3000000;
    localparam logic [MARKS_W-1:0] OUTER_MK_RST  = 8'd8;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEB_MIN  = 2'd0;
    localparam logic [1:0] REG_DEB_MAX  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;
    localparam logic [1:0] REG_OUTER_MK = 2'd3;

    // item operations and sensor ids
    localparam logic OP_EDGE     = 1'b0;
    localparam logic OP_CHECK    = 1'b1;
    localparam logic SENSOR_INNER = 1'b0;
    localparam logic SENSOR_OUTER = 1'b1;

    // debounce clamp limits
    typedef struct packed {
        logic [DEB_W-1:0] lo;
        logic [DEB_W-1:0] hi;
    } t_deb_limits;

endpackage

`default_nettype wire

// ===== src/irtp_debounce.sv =====
// adaptive debounce time: period divided by the divisor, clamped to the limits
`default_nettype none

module irtp_debounce
    import irtp_pkg::*;
(
    input  wire logic [TIME_W-1:0] i_period,
    input  wire t_deb_limits       i_limits,
    output logic [DEB_W-1:0]       o_debounce
);

    logic [DIV_SHIFT+TIME_W-1:0] w_prod;
    logic [TIME_W-1:0]           w_quot;

    // divide by constant through the reciprocal
    assign w_prod = (DIV_SHIFT+TIME_W)'(i_period) * (DIV_SHIFT+TIME_W)'(DIV_MAGIC);
    assign w_quot = w_prod[DIV_SHIFT +: TIME_W];

    // below min gives min, else above max gives max
    always_comb begin
        if (w_quot < {8'd0, i_limits.lo}) begin
            o_debounce = i_limits.lo;
        end else if (w_quot > {8'd0, i_limits.hi}) begin
            o_debounce = i_limits.hi;
        end else begin
            o_debounce = w_quot[DEB_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/ir_tachometer_position_tracker_top.sv =====
// tachometer with adaptive debounce and index-referenced position, top level
// the result item of an accepted item is held in the output register in the next cycle
// throughput: one item per cycle unless the output stalls; sensor state is updated
// at accept so the next item sees it at once, path: subtract, constant divide, clamp
// reset: synchronous active-low i_rst_n clears sensor state, position and
// output valid, and returns the configuration registers to their defaults
`default_nettype none

module ir_tachometer_position_tracker_top
    import irtp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // input items
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [31:0]       s_axis_tdata,   // time_us[31:0]
    input  wire logic [1:0]        s_axis_tuser,   // operation[0], sensor_id[1]
    // result items
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // edge_accepted[0], period_us[32:1], pass_total[64:33], debounce_now_us[88:65],
    // position_valid[89], position_index[97:90], timed_out[98], zero[103:99]
    output logic [103:0]           m_axis_tdata
);

    // configuration registers
    logic [DEB_W-1:0]   r_deb_min;
    logic [DEB_W-1:0]   r_deb_max;
    logic [TIME_W-1:0]  r_timeout;
    logic [MARKS_W-1:0] r_outer_mk;

    // per-sensor state
    logic [TIME_W-1:0] r_last [2];
    logic [TIME_W-1:0] r_prev [2];
    logic [TIME_W-1:0] r_period [2];
    logic [TIME_W-1:0] r_count [2];
    logic [DEB_W-1:0]  r_deb [2];
    logic [1:0]        r_active;
    logic [TIME_W-1:0] n_last [2];
    logic [TIME_W-1:0] n_prev [2];
    logic [TIME_W-1:0] n_period [2];
    logic [TIME_W-1:0] n_count [2];
    logic [DEB_W-1:0]  n_deb [2];
    logic [1:0]        n_active;

    // shared position state
    logic               r_index_seen;
    logic               r_zero_next;
    logic [MARKS_W-1:0] r_mark;
    logic               n_index_seen;
    logic               n_zero_next;
    logic [MARKS_W-1:0] n_mark;

    // output register
    logic         r_m_valid;
    logic [103:0] r_m_data;
    logic [103:0] n_m_data;

    logic              w_accept;
    logic              w_op;
    logic              w_sid;
    logic [TIME_W-1:0] w_time;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_edge_ok;
    logic              w_tout;
    logic [TIME_W-1:0] w_period_new;
    logic [DEB_W-1:0]  w_deb_calc;
    logic [MARKS_W:0]  w_mark_inc;
    logic              w_cfg_wr;
    t_deb_limits       w_limits;

    // register access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_DEB_MIN:  prdata = {8'd0, r_deb_min};
            REG_DEB_MAX:  prdata = {8'd0, r_deb_max};
            REG_TIMEOUT:  prdata = r_timeout;
            REG_OUTER_MK: prdata = {24'd0, r_outer_mk};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_min  <= DEB_MIN_RST;
            r_deb_max  <= DEB_MAX_RST;
            r_timeout  <= TIMEOUT_RST;
            r_outer_mk <= OUTER_MK_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_DEB_MIN:  r_deb_min  <= pwdata[DEB_W-1:0];
                REG_DEB_MAX:  r_deb_max  <= pwdata[DEB_W-1:0];
                REG_TIMEOUT:  r_timeout  <= pwdata;
                REG_OUTER_MK: r_outer_mk <= pwdata[MARKS_W-1:0];
                default:      r_timeout  <= r_timeout;
            endcase
        end
    end

    // handshake: take an item whenever the output register is free or draining
    assign s_axis_tready = ~r_m_valid | m_axis_tready;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign w_op   = s_axis_tuser[0];
    assign w_sid  = s_axis_tuser[1];
    assign w_time = s_axis_tdata;

    // debounce and timeout tests against the addressed sensor
    assign w_elapsed    = w_time - r_last[w_sid];
    assign w_edge_ok    = (w_op == OP_EDGE) && (w_elapsed > {8'd0, r_deb[w_sid]});
    assign w_tout       = (w_op == OP_CHECK) && r_active[w_sid] && (w_elapsed > r_timeout);
    assign w_period_new = (r_prev[w_sid] != '0) ? (w_time - r_prev[w_sid]) : '0;
    assign w_mark_inc   = {1'b0, r_mark} + 9'd1;

    assign w_limits.lo = r_deb_min;
    assign w_limits.hi = r_deb_max;

    irtp_debounce u_debounce (
        .i_period   (w_period_new),
        .i_limits   (w_limits),
        .o_debounce (w_deb_calc)
    );

    // next state for the accepted item
    always_comb begin
        n_last       = r_last;
        n_prev       = r_prev;
        n_period     = r_period;
        n_count      = r_count;
        n_deb        = r_deb;
        n_active     = r_active;
        n_index_seen = r_index_seen;
        n_zero_next  = r_zero_next;
        n_mark       = r_mark;
        if (w_accept && w_edge_ok) begin
            n_period[w_sid] = w_period_new;
            n_prev[w_sid]   = w_time;
            n_last[w_sid]   = w_time;
            n_count[w_sid]  = r_count[w_sid] + 32'd1;
            if (r_active[w_sid] || (w_period_new != '0)) begin
                n_deb[w_sid] = w_deb_calc;
            end
            n_active[w_sid] = 1'b1;
            // index edge arms the zeroing, outer edges count marks
            if (w_sid == SENSOR_INNER) begin
                n_index_seen = 1'b1;
                n_zero_next  = 1'b1;
            end else if (r_index_seen) begin
                if (r_zero_next) begin
                    n_mark      = '0;
                    n_zero_next = 1'b0;
                end else if (w_mark_inc >= {1'b0, r_outer_mk}) begin
                    n_mark = '0;
                end else begin
                    n_mark = w_mark_inc[MARKS_W-1:0];
                end
            end
        end else if (w_accept && w_tout) begin
            n_period[w_sid] = '0;
            n_last[w_sid]   = '0;
            n_prev[w_sid]   = '0;
            n_deb[w_sid]    = r_deb_max;
            n_active[w_sid] = 1'b0;
        end
    end

    // result item shows the addressed sensor after the update
    always_comb begin
        n_m_data         = '0;
        n_m_data[0]      = w_edge_ok;
        n_m_data[32:1]   = n_period[w_sid];
        n_m_data[64:33]  = n_count[w_sid];
        n_m_data[88:65]  = n_deb[w_sid];
        n_m_data[89]     = n_index_seen;
        n_m_data[97:90]  = n_mark;
        n_m_data[98]     = w_tout;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_last[i]   <= '0;
                r_prev[i]   <= '0;
                r_period[i] <= '0;
                r_count[i]  <= '0;
                r_deb[i]    <= DEB_MAX_RST;
            end
            r_active     <= '0;
            r_index_seen <= 1'b0;
            r_zero_next  <= 1'b0;
            r_mark       <= '0;
        end else begin
            r_last       <= n_last;
            r_prev       <= n_prev;
            r_period     <= n_period;
            r_count      <= n_count;
            r_deb        <= n_deb;
            r_active     <= n_active;
            r_index_seen <= n_index_seen;
            r_zero_next  <= n_zero_next;
            r_mark       <= n_mark;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_m_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
        end
    end

endmodule

`default_nettype wire
